@@ hw/rtl/rtc_pkg.sv @@
// Shared types, constants and the multiply-accumulate program of the ray/triangle tester.
package rtc_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned T_W         = 31;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned STEP_W      = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd6;

  // Vector components.
  localparam logic [1:0] CX = 2'd0;
  localparam logic [1:0] CY = 2'd1;
  localparam logic [1:0] CZ = 2'd2;

  // Program steps after which the sequencer checks or divides.
  localparam logic [STEP_W-1:0] STEP_DET_END = 5'd8;
  localparam logic [STEP_W-1:0] STEP_U_END   = 5'd11;
  localparam logic [STEP_W-1:0] STEP_V_END   = 5'd20;
  localparam logic [STEP_W-1:0] STEP_T_END   = 5'd23;

  typedef enum logic [1:0] {BS_E1, BS_E2, BS_REL, BS_DIR} bsel_e;
  typedef enum logic [1:0] {AS_E1, AS_E2, AS_PV, AS_QV} asel_e;
  typedef enum logic [3:0] {
    MD_NONE, MD_PV_X, MD_PV_Y, MD_PV_Z, MD_QV_X, MD_QV_Y, MD_QV_Z, MD_DET, MD_NUM
  } mdst_e;
  typedef enum logic [1:0] {DV_U, DV_V, DV_T} ddst_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC_GO, ST_MAC_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_CHK, ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    bsel_e      b_sel;
    logic [1:0] b_c;
    asel_e      a_sel;
    logic [1:0] a_c;
    logic       clr;
    logic       sub;
    mdst_e      dst;
  } mac_cmd_t;

  typedef struct packed {
    logic     load;
    logic     mac_go;
    mac_cmd_t mac;
    logic     div_go;
    ddst_e    div_dst;
    logic     commit;
    logic     emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic det_ok;
    logic u_ok;
    logic v_ok;
    logic t_ok;
    logic out_free;
  } ctl_sts_t;

  function automatic mac_cmd_t mk(input bsel_e bs, input logic [1:0] bc, input asel_e as,
                                  input logic [1:0] ac, input logic clr, input logic sub,
                                  input mdst_e dst);
    mac_cmd_t m;
    m.b_sel = bs;
    m.b_c   = bc;
    m.a_sel = as;
    m.a_c   = ac;
    m.clr   = clr;
    m.sub   = sub;
    m.dst   = dst;
    return m;
  endfunction

  // pv = dir x e2, det = e1.pv, u num = rel.pv, qv = rel x e1, v num = dir.qv, t num = e2.qv.
  function automatic mac_cmd_t mac_prog(input logic [STEP_W-1:0] s);
    mac_cmd_t m;
    case (s)
      5'd0:    m = mk(BS_DIR, CY, AS_E2, CZ, 1'b1, 1'b0, MD_NONE);
      5'd1:    m = mk(BS_DIR, CZ, AS_E2, CY, 1'b0, 1'b1, MD_PV_X);
      5'd2:    m = mk(BS_DIR, CZ, AS_E2, CX, 1'b1, 1'b0, MD_NONE);
      5'd3:    m = mk(BS_DIR, CX, AS_E2, CZ, 1'b0, 1'b1, MD_PV_Y);
      5'd4:    m = mk(BS_DIR, CX, AS_E2, CY, 1'b1, 1'b0, MD_NONE);
      5'd5:    m = mk(BS_DIR, CY, AS_E2, CX, 1'b0, 1'b1, MD_PV_Z);
      5'd6:    m = mk(BS_E1, CX, AS_PV, CX, 1'b1, 1'b0, MD_NONE);
      5'd7:    m = mk(BS_E1, CY, AS_PV, CY, 1'b0, 1'b0, MD_NONE);
      5'd8:    m = mk(BS_E1, CZ, AS_PV, CZ, 1'b0, 1'b0, MD_DET);
      5'd9:    m = mk(BS_REL, CX, AS_PV, CX, 1'b1, 1'b0, MD_NONE);
      5'd10:   m = mk(BS_REL, CY, AS_PV, CY, 1'b0, 1'b0, MD_NONE);
      5'd11:   m = mk(BS_REL, CZ, AS_PV, CZ, 1'b0, 1'b0, MD_NUM);
      5'd12:   m = mk(BS_REL, CY, AS_E1, CZ, 1'b1, 1'b0, MD_NONE);
      5'd13:   m = mk(BS_REL, CZ, AS_E1, CY, 1'b0, 1'b1, MD_QV_X);
      5'd14:   m = mk(BS_REL, CZ, AS_E1, CX, 1'b1, 1'b0, MD_NONE);
      5'd15:   m = mk(BS_REL, CX, AS_E1, CZ, 1'b0, 1'b1, MD_QV_Y);
      5'd16:   m = mk(BS_REL, CX, AS_E1, CY, 1'b1, 1'b0, MD_NONE);
      5'd17:   m = mk(BS_REL, CY, AS_E1, CX, 1'b0, 1'b1, MD_QV_Z);
      5'd18:   m = mk(BS_DIR, CX, AS_QV, CX, 1'b1, 1'b0, MD_NONE);
      5'd19:   m = mk(BS_DIR, CY, AS_QV, CY, 1'b0, 1'b0, MD_NONE);
      5'd20:   m = mk(BS_DIR, CZ, AS_QV, CZ, 1'b0, 1'b0, MD_NUM);
      5'd21:   m = mk(BS_E2, CX, AS_QV, CX, 1'b1, 1'b0, MD_NONE);
      5'd22:   m = mk(BS_E2, CY, AS_QV, CY, 1'b0, 1'b0, MD_NONE);
      5'd23:   m = mk(BS_E2, CZ, AS_QV, CZ, 1'b0, 1'b0, MD_NUM);
      default: m = mk(BS_E1, CX, AS_E1, CX, 1'b1, 1'b0, MD_NONE);
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/rtc_if.sv @@
// Handshake interfaces for the triangle, result and configuration channels.
interface rtc_tri_if #(parameter int unsigned CW = rtc_pkg::COORD_WIDTH);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] a_z;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_z;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;
  logic signed [CW-1:0] c_z;
  logic [31:0]          tri_id;
  logic                 new_ray;
  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_id, new_ray,
                 input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_id, new_ray,
               output ready);
endinterface

interface rtc_res_if #(parameter int unsigned UVW = rtc_pkg::FRAC_BITS + 1);
  logic           valid;
  logic           ready;
  logic           hit_here;
  logic           any_hit;
  logic [30:0]    best_t;
  logic [UVW-1:0] best_u;
  logic [UVW-1:0] best_v;
  logic [31:0]    best_id;
  modport source(output valid, hit_here, any_hit, best_t, best_u, best_v, best_id,
                 input ready);
  modport sink(input valid, hit_here, any_hit, best_t, best_u, best_v, best_id,
               output ready);
endinterface

interface rtc_cfg_if #(parameter int unsigned DATA_W = rtc_pkg::COORD_WIDTH);
  logic                           valid;
  logic                           ready;
  logic [rtc_pkg::CFG_IDX_W-1:0]  idx;
  logic [DATA_W-1:0]              data;
  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

@@ hw/rtl/rtc_ctrl.sv @@
// Sequencer that steps the multiply-accumulate program, the divisions and the hit checks.
module rtc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rtc_pkg::ctl_sts_t   sts_i,
  output rtc_pkg::ctl_cmd_t   cmd_o
);

  rtc_pkg::ctl_state_e state_q, state_d;
  logic [rtc_pkg::STEP_W-1:0] step_q, step_d;
  logic div_step;

  assign div_step = (step_q == rtc_pkg::STEP_U_END) || (step_q == rtc_pkg::STEP_V_END) ||
                    (step_q == rtc_pkg::STEP_T_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtc_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      rtc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rtc_pkg::ST_MAC_GO;
          step_d  = '0;
        end
      end
      rtc_pkg::ST_MAC_GO: state_d = rtc_pkg::ST_MAC_WAIT;
      rtc_pkg::ST_MAC_WAIT: begin
        if (sts_i.mul_done) begin
          if (step_q == rtc_pkg::STEP_DET_END) begin
            state_d = rtc_pkg::ST_CHK;
          end else if (div_step) begin
            state_d = rtc_pkg::ST_DIV_GO;
          end else begin
            state_d = rtc_pkg::ST_MAC_GO;
            step_d  = step_q + 1'b1;
          end
        end
      end
      rtc_pkg::ST_DIV_GO: state_d = rtc_pkg::ST_DIV_WAIT;
      rtc_pkg::ST_DIV_WAIT: begin
        if (sts_i.div_done) state_d = rtc_pkg::ST_CHK;
      end
      rtc_pkg::ST_CHK: begin
        state_d = rtc_pkg::ST_EMIT;
        case (step_q)
          rtc_pkg::STEP_DET_END: begin
            if (sts_i.det_ok) begin
              state_d = rtc_pkg::ST_MAC_GO;
              step_d  = step_q + 1'b1;
            end
          end
          rtc_pkg::STEP_U_END: begin
            if (sts_i.u_ok) begin
              state_d = rtc_pkg::ST_MAC_GO;
              step_d  = step_q + 1'b1;
            end
          end
          rtc_pkg::STEP_V_END: begin
            if (sts_i.v_ok) begin
              state_d = rtc_pkg::ST_MAC_GO;
              step_d  = step_q + 1'b1;
            end
          end
          default: state_d = rtc_pkg::ST_EMIT;
        endcase
      end
      rtc_pkg::ST_EMIT: begin
        if (sts_i.out_free) state_d = rtc_pkg::ST_IDLE;
      end
      default: state_d = rtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mac     = rtc_pkg::mac_prog(step_q);
    cmd_o.div_dst = rtc_pkg::DV_T;
    in_ready_o    = (state_q == rtc_pkg::ST_IDLE);
    case (step_q)
      rtc_pkg::STEP_U_END: cmd_o.div_dst = rtc_pkg::DV_U;
      rtc_pkg::STEP_V_END: cmd_o.div_dst = rtc_pkg::DV_V;
      default:             cmd_o.div_dst = rtc_pkg::DV_T;
    endcase
    case (state_q)
      rtc_pkg::ST_IDLE:   cmd_o.load   = in_valid_i;
      rtc_pkg::ST_MAC_GO: cmd_o.mac_go = 1'b1;
      rtc_pkg::ST_DIV_GO: cmd_o.div_go = 1'b1;
      rtc_pkg::ST_CHK:    cmd_o.commit = (step_q == rtc_pkg::STEP_T_END) && sts_i.t_ok;
      rtc_pkg::ST_EMIT:   cmd_o.emit   = sts_i.out_free;
      default:            cmd_o.load   = 1'b0;
    endcase
  end

  a_mac_go_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac_go |=> state_q == rtc_pkg::ST_MAC_WAIT)
    else $error("multiply start not followed by wait");
  a_load_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> step_q == '0)
    else $error("program did not restart on a new item");
  a_commit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> step_q == rtc_pkg::STEP_T_END)
    else $error("commit outside the distance check");

endmodule

@@ hw/rtl/rtc_dpath.sv @@
// Datapath: ray registers, edge vectors, digit-serial multiplier, restoring divider, best hit.
module rtc_dpath #(
  parameter int unsigned CW = rtc_pkg::COORD_WIDTH,
  parameter int unsigned F  = rtc_pkg::FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rtc_cfg_if.sink           cfg_i,
  rtc_tri_if.sink           tri_i,
  rtc_res_if.source         res_o,
  input  rtc_pkg::ctl_cmd_t cmd_i,
  output rtc_pkg::ctl_sts_t sts_o
);

  localparam int unsigned DW    = CW + 1;
  localparam int unsigned XW    = 2 * DW + 1;
  localparam int unsigned PRW   = DW + XW;
  localparam int unsigned PW    = PRW + 2;
  localparam int unsigned NW    = PW + F;
  localparam int unsigned QW    = NW + 1;
  localparam int unsigned DIG   = 16;
  localparam int unsigned NDIG  = (XW + DIG - 1) / DIG;
  localparam int unsigned MW    = NDIG * DIG;
  localparam int unsigned MCW   = $clog2(NDIG + 1);
  localparam int unsigned DCW   = $clog2(NW + 1);
  localparam int unsigned UVW   = F + 1;
  localparam int unsigned TW    = rtc_pkg::T_W;
  localparam int unsigned EPSR  = ((1 << F) + 5000) / 10000;
  localparam logic signed [CW-1:0] ONE_C = CW'(1) << F;
  localparam logic signed [QW-1:0] ONE_Q = QW'(1) << F;
  localparam logic signed [QW-1:0] EPS_Q = QW'(EPSR);
  localparam logic signed [PW-1:0] EPS_D = PW'(EPSR) << (2 * F);

  // Ray configuration.
  logic signed [CW-1:0] org_q [3];
  logic signed [CW-1:0] dir_q [3];
  logic [TW-1:0]        start_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q   <= '{default: '0};
      dir_q   <= '{'0, '0, ONE_C};
      start_q <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        rtc_pkg::CFG_ORG_X: org_q[0] <= cfg_i.data[CW-1:0];
        rtc_pkg::CFG_ORG_Y: org_q[1] <= cfg_i.data[CW-1:0];
        rtc_pkg::CFG_ORG_Z: org_q[2] <= cfg_i.data[CW-1:0];
        rtc_pkg::CFG_DIR_X: dir_q[0] <= cfg_i.data[CW-1:0];
        rtc_pkg::CFG_DIR_Y: dir_q[1] <= cfg_i.data[CW-1:0];
        rtc_pkg::CFG_DIR_Z: dir_q[2] <= cfg_i.data[CW-1:0];
        rtc_pkg::CFG_START: start_q  <= cfg_i.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Edge vectors captured when an item is taken.
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [DW-1:0] rel_q [3];
  logic [31:0]          id_q;

  assign va = '{tri_i.a_x, tri_i.a_y, tri_i.a_z};
  assign vb = '{tri_i.b_x, tri_i.b_y, tri_i.b_z};
  assign vc = '{tri_i.c_x, tri_i.c_y, tri_i.c_z};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k]  <= DW'(vb[k]) - DW'(va[k]);
        e2_q[k]  <= DW'(vc[k]) - DW'(va[k]);
        rel_q[k] <= DW'(org_q[k]) - DW'(va[k]);
      end
      id_q <= tri_i.tri_id;
    end
  end

  // Operand selection for the multiplier.
  logic signed [DW-1:0] b_op;
  logic signed [XW-1:0] a_op;
  logic [DW-1:0]        b_mag;
  logic [XW-1:0]        a_mag;
  logic signed [XW-1:0] pv_q [3];
  logic signed [XW-1:0] qv_q [3];

  always_comb begin
    case (cmd_i.mac.b_sel)
      rtc_pkg::BS_E1:  b_op = e1_q[cmd_i.mac.b_c];
      rtc_pkg::BS_E2:  b_op = e2_q[cmd_i.mac.b_c];
      rtc_pkg::BS_REL: b_op = rel_q[cmd_i.mac.b_c];
      rtc_pkg::BS_DIR: b_op = DW'(dir_q[cmd_i.mac.b_c]);
      default:         b_op = '0;
    endcase
    case (cmd_i.mac.a_sel)
      rtc_pkg::AS_E1: a_op = XW'(e1_q[cmd_i.mac.a_c]);
      rtc_pkg::AS_E2: a_op = XW'(e2_q[cmd_i.mac.a_c]);
      rtc_pkg::AS_PV: a_op = pv_q[cmd_i.mac.a_c];
      rtc_pkg::AS_QV: a_op = qv_q[cmd_i.mac.a_c];
      default:        a_op = '0;
    endcase
    b_mag = b_op[DW-1] ? DW'(-b_op) : DW'(b_op);
    a_mag = a_op[XW-1] ? XW'(-a_op) : XW'(a_op);
  end

  // Digit-serial multiplier: the long operand enters one DIG-bit digit per cycle,
  // most significant digit first, against the full short operand.
  logic [DW-1:0]        ma_q;
  logic [MW-1:0]        mb_q;
  logic [PRW-1:0]       prod_q;
  logic [DW+DIG-1:0]    mpart;
  logic [MCW-1:0]       mcnt_q;
  logic                 mneg_q, mclr_q, mul_busy_q, mul_done;
  rtc_pkg::mdst_e       mdst_q;
  logic signed [PW-1:0] acc_q, acc_new, prod_ext, det_q, num_q;

  assign mpart    = ma_q * mb_q[MW-1 -: DIG];
  assign mul_done = mul_busy_q && (mcnt_q == '0);
  assign prod_ext = $signed({2'b00, prod_q});
  assign acc_new  = (mclr_q ? PW'(0) : acc_q) + (mneg_q ? -prod_ext : prod_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
    end else if (cmd_i.mac_go) begin
      mul_busy_q <= 1'b1;
    end else if (mul_done) begin
      mul_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_go) begin
      ma_q   <= b_mag;
      mb_q   <= MW'(a_mag);
      prod_q <= '0;
      mneg_q <= a_op[XW-1] ^ b_op[DW-1] ^ cmd_i.mac.sub;
      mclr_q <= cmd_i.mac.clr;
      mdst_q <= cmd_i.mac.dst;
      mcnt_q <= MCW'(NDIG);
    end else if (mul_busy_q && (mcnt_q != '0)) begin
      prod_q <= (prod_q << DIG) + PRW'(mpart);
      mb_q   <= mb_q << DIG;
      mcnt_q <= mcnt_q - 1'b1;
    end
    if (mul_done) begin
      acc_q <= acc_new;
      case (mdst_q)
        rtc_pkg::MD_PV_X: pv_q[0] <= XW'(acc_new);
        rtc_pkg::MD_PV_Y: pv_q[1] <= XW'(acc_new);
        rtc_pkg::MD_PV_Z: pv_q[2] <= XW'(acc_new);
        rtc_pkg::MD_QV_X: qv_q[0] <= XW'(acc_new);
        rtc_pkg::MD_QV_Y: qv_q[1] <= XW'(acc_new);
        rtc_pkg::MD_QV_Z: qv_q[2] <= XW'(acc_new);
        rtc_pkg::MD_DET:  det_q   <= acc_new;
        rtc_pkg::MD_NUM:  num_q   <= acc_new;
        default: ;
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle, truncating toward zero.
  logic [PW-1:0]        d_q;
  logic [NW-1:0]        n_q, quo_q;
  logic [PW:0]          rem_q, rem_sh;
  logic [DCW-1:0]       dcnt_q;
  logic                 qneg_q, div_busy_q, div_done, rem_ge;
  rtc_pkg::ddst_e       ddst_q;
  logic signed [QW-1:0] quo_s, bu_q, bv_q, bt_q;
  logic [PW-1:0]        det_mag, num_mag;

  assign det_mag  = det_q[PW-1] ? PW'(-det_q) : PW'(det_q);
  assign num_mag  = num_q[PW-1] ? PW'(-num_q) : PW'(num_q);
  assign rem_sh   = {rem_q[PW-1:0], n_q[NW-1]};
  assign rem_ge   = rem_sh >= {1'b0, d_q};
  assign div_done = div_busy_q && (dcnt_q == '0);
  assign quo_s    = qneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else if (cmd_i.div_go) begin
      div_busy_q <= 1'b1;
    end else if (div_done) begin
      div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      d_q    <= det_mag;
      n_q    <= {num_mag, {F{1'b0}}};
      rem_q  <= '0;
      quo_q  <= '0;
      qneg_q <= det_q[PW-1] ^ num_q[PW-1];
      ddst_q <= cmd_i.div_dst;
      dcnt_q <= DCW'(NW);
    end else if (div_busy_q && (dcnt_q != '0)) begin
      rem_q  <= rem_ge ? rem_sh - {1'b0, d_q} : rem_sh;
      n_q    <= n_q << 1;
      quo_q  <= {quo_q[NW-2:0], rem_ge};
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (div_done) begin
      case (ddst_q)
        rtc_pkg::DV_U: bu_q <= quo_s;
        rtc_pkg::DV_V: bv_q <= quo_s;
        default:       bt_q <= quo_s;
      endcase
    end
  end

  // Closest hit so far.
  logic [TW-1:0]  near_t_q;
  logic [UVW-1:0] near_u_q, near_v_q;
  logic [31:0]    near_id_q;
  logic           seen_q, hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_t_q  <= '1;
      near_u_q  <= '0;
      near_v_q  <= '0;
      near_id_q <= '0;
      seen_q    <= 1'b0;
      hit_q     <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
      if (tri_i.new_ray) begin
        near_t_q  <= start_q;
        near_u_q  <= '0;
        near_v_q  <= '0;
        near_id_q <= '0;
        seen_q    <= 1'b0;
      end
    end else if (cmd_i.commit) begin
      near_t_q  <= bt_q[TW-1:0];
      near_u_q  <= bu_q[UVW-1:0];
      near_v_q  <= bv_q[UVW-1:0];
      near_id_q <= id_q;
      seen_q    <= 1'b1;
      hit_q     <= 1'b1;
    end
  end

  // Acceptance checks.
  logic signed [QW:0] uv_sum;

  assign uv_sum          = (QW + 1)'(bu_q) + (QW + 1)'(bv_q);
  assign sts_o.mul_done  = mul_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.det_ok    = (det_q > EPS_D) || (det_q < -EPS_D);
  assign sts_o.u_ok      = !bu_q[QW-1] && (bu_q <= ONE_Q);
  assign sts_o.v_ok      = !bv_q[QW-1] && (uv_sum <= (QW + 1)'(ONE_Q));
  assign sts_o.t_ok      = (bt_q > EPS_Q) && (bt_q < $signed(QW'(near_t_q)));
  assign sts_o.out_free  = !res_o.valid || res_o.ready;

  // Result register.
  logic res_valid_q;

  assign res_o.valid = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_o.hit_here <= hit_q;
      res_o.any_hit  <= seen_q;
      res_o.best_t   <= near_t_q;
      res_o.best_u   <= near_u_q;
      res_o.best_v   <= near_v_q;
      res_o.best_id  <= near_id_q;
    end
  end

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy_q && div_busy_q))
    else $error("multiplier and divider busy together");
  a_commit_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> seen_q && hit_q)
    else $error("commit did not record the hit");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("result written over an untaken item");

endmodule

@@ hw/rtl/ray_triangle_closest_hit_top.sv @@
// A triangle that reaches the distance check runs 24 multiply-accumulates, three divisions
// and four checks before its result is emitted. One item is in work at a time: a new
// triangle is taken only once the result of the last one has gone into the result register.
// Reset clears control, ray registers and best hit.
module ray_triangle_closest_hit_top #(
  parameter int unsigned COORD_WIDTH = rtc_pkg::COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = rtc_pkg::FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  rtc_cfg_if.sink   cfg_i,
  rtc_tri_if.sink   tri_i,
  rtc_res_if.source res_o
);

  rtc_pkg::ctl_cmd_t cmd;
  rtc_pkg::ctl_sts_t sts;
  logic              in_ready;

  assign tri_i.ready = in_ready;

  rtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tri_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtc_dpath #(
    .CW (COORD_WIDTH),
    .F  (FRAC_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .tri_i  (tri_i),
    .res_o  (res_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
